FILE: hw/rtl/plbf_pkg.sv
// Shared types, sizes and helpers for the PCM latency-bounded FIFO.
package plbf_pkg;

  // Sample store geometry
  localparam int FIFO_DEPTH = 4096;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int TGT_W    = 13;
  localparam int FILL_W   = 13;
  localparam int TOT_W    = 64;
  localparam int CMD_W    = 2;
  localparam int FLAG_N   = 3;

  // Target fill after reset
  localparam logic [TGT_W-1:0] TGT_RESET = TGT_W'(1920);

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLAGS = 2'd2;

  // Classified operation codes between front and back
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP   = 2'd2;
  localparam logic [OP_W-1:0] OP_FLAGS = 2'd3;

  // Request queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // Result queue at the output
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [SAMPLE_W-1:0] sample_in;
    logic                feed_on;
    logic                capture_on;
    logic                protect_on;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    logic                sample_real;
    logic [FILL_W-1:0]   fill_samples;
    logic [TOT_W-1:0]    overflow_bytes;
    logic [TOT_W-1:0]    underflow_bytes;
    logic [TOT_W-1:0]    clear_count;
  } out_item_t;

  // Classified request: flags ordered feed, capture, protect (msb first)
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] sample;
    logic [FLAG_N-1:0]   flags;
  } req_t;

  // Advance a store pointer by n entries, n at most FIFO_DEPTH
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] n);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(p) + (CNT_W + 1)'(n);
    if (s >= (CNT_W + 1)'(FIFO_DEPTH)) begin
      s = s - (CNT_W + 1)'(FIFO_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/plbf_front.sv
// Front end: accepts input requests, classifies them and queues them for the back end.
module plbf_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  plbf_pkg::in_item_t     in_data,
  output logic                   req_valid,
  output plbf_pkg::req_t         req,
  input  logic                   req_take
);
  import plbf_pkg::*;

  req_t                entry_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r;
  logic [CQ_PTR_W-1:0] rd_ptr_r;
  logic [CQ_CNT_W-1:0] count_r;
  logic                acc;
  logic                take;
  req_t                cls;

  assign full      = (count_r == CQ_CNT_W'(CQ_DEPTH));
  assign acc       = push && !full;
  assign req_valid = (count_r != '0);
  assign take      = req_take && req_valid;
  assign req       = entry_r[rd_ptr_r];

  // Classify the incoming command
  always_comb begin
    cls.sample = in_data.sample_in;
    cls.flags  = {in_data.feed_on, in_data.capture_on, in_data.protect_on};
    case (in_data.cmd)
      CMD_PUSH:  cls.op = OP_PUSH;
      CMD_POP:   cls.op = OP_POP;
      CMD_FLAGS: cls.op = OP_FLAGS;
      default:   cls.op = OP_NOP;
    endcase
  end

  // Store accepted requests
  always_ff @(posedge clk) begin
    if (acc) begin
      entry_r[wr_ptr_r] <= cls;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (acc) begin
        wr_ptr_r <= (wr_ptr_r == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (take) begin
        rd_ptr_r <= (rd_ptr_r == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({acc, take})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: hw/rtl/plbf_back.sv
// Back end: sample store, fill control, gating flags and running totals.
module plbf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [plbf_pkg::TGT_W-1:0]    cfg_wdata,
  input  logic                          req_valid,
  input  plbf_pkg::req_t                req,
  output logic                          req_take,
  input  logic [plbf_pkg::OQ_CNT_W-1:0] oq_level,
  output logic                          res_valid,
  output plbf_pkg::out_item_t           res
);
  import plbf_pkg::*;

  logic [SAMPLE_W-1:0] mem [FIFO_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  logic [TGT_W-1:0]  target_r;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [FLAG_N-1:0] flags_r, flags_nxt;
  logic [TOT_W-1:0]  ovf_r, ovf_nxt;
  logic [TOT_W-1:0]  unf_r, unf_nxt;
  logic [TOT_W-1:0]  clr_r, clr_nxt;

  logic              s1_valid_r;
  logic              s1_real_r;
  logic [FILL_W-1:0] s1_fill_r;
  logic [TOT_W-1:0]  s1_ovf_r, s1_unf_r, s1_clr_r;

  logic              is_open;
  logic [CNT_W-1:0]  tgt;
  logic              room;
  logic              issue;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic              rd_en;
  logic              real_nxt;
  logic [CNT_W:0]    excess;
  logic [FLAG_N-1:0] chg;

  // Path is open when feed and capture run and protection is off
  assign is_open = flags_r[2] && flags_r[1] && !flags_r[0];

  // Clamp the target to the store depth
  assign tgt = (32'(target_r) > 32'(FIFO_DEPTH)) ? CNT_W'(FIFO_DEPTH) : CNT_W'(target_r);

  // Issue only with a result queue slot reserved for the request in flight
  assign room     = ((OQ_CNT_W + 1)'(oq_level) + (OQ_CNT_W + 1)'(s1_valid_r))
                    < (OQ_CNT_W + 1)'(OQ_DEPTH);
  assign issue    = req_valid && room;
  assign req_take = issue;

  assign excess  = (CNT_W + 1)'(held_r) + 1'b1 - (CNT_W + 1)'(tgt);
  assign chg     = flags_r ^ req.flags;
  assign wr_addr = ptr_add(rp_r, held_r);

  // Execute one request against the state
  always_comb begin
    rp_nxt    = rp_r;
    held_nxt  = held_r;
    flags_nxt = flags_r;
    ovf_nxt   = ovf_r;
    unf_nxt   = unf_r;
    clr_nxt   = clr_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    real_nxt  = 1'b0;
    if (issue) begin
      case (req.op)
        OP_PUSH: begin
          if (is_open) begin
            if (held_r >= tgt) begin
              // Drop oldest samples down to target, then store unless target is zero
              ovf_nxt  = ovf_r + TOT_W'({excess, 1'b0});
              rp_nxt   = ptr_add(rp_r, (tgt == '0) ? held_r : excess[CNT_W-1:0]);
              held_nxt = tgt;
              wr_en    = (tgt != '0);
            end else begin
              held_nxt = held_r + 1'b1;
              wr_en    = 1'b1;
            end
          end
        end
        OP_POP: begin
          if (is_open && held_r != '0) begin
            rd_en    = 1'b1;
            real_nxt = 1'b1;
            rp_nxt   = ptr_add(rp_r, CNT_W'(1));
            held_nxt = held_r - 1'b1;
          end else begin
            unf_nxt = unf_r + TOT_W'(2);
          end
        end
        OP_FLAGS: begin
          flags_nxt = req.flags;
          if (chg != '0) begin
            rp_nxt   = '0;
            held_nxt = '0;
            clr_nxt  = clr_r + TOT_W'(chg[0]) + TOT_W'(chg[1]) + TOT_W'(chg[2]);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sample store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req.sample;
    end
    if (rd_en) begin
      rd_data_r <= mem[rp_r];
    end
  end

  // Hold state and the target register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= TGT_RESET;
      rp_r       <= '0;
      held_r     <= '0;
      flags_r    <= '0;
      ovf_r      <= '0;
      unf_r      <= '0;
      clr_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
      rp_r       <= rp_nxt;
      held_r     <= held_nxt;
      flags_r    <= flags_nxt;
      ovf_r      <= ovf_nxt;
      unf_r      <= unf_nxt;
      clr_r      <= clr_nxt;
      s1_valid_r <= issue;
    end
  end

  // Capture the result fields alongside the store read
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_real_r <= real_nxt;
      s1_fill_r <= FILL_W'(held_nxt);
      s1_ovf_r  <= ovf_nxt;
      s1_unf_r  <= unf_nxt;
      s1_clr_r  <= clr_nxt;
    end
  end

  assign res_valid           = s1_valid_r;
  assign res.sample_out      = s1_real_r ? rd_data_r : '0;
  assign res.sample_real     = s1_real_r;
  assign res.fill_samples    = s1_fill_r;
  assign res.overflow_bytes  = s1_ovf_r;
  assign res.underflow_bytes = s1_unf_r;
  assign res.clear_count     = s1_clr_r;

endmodule

FILE: hw/rtl/plbf_outq.sv
// Result queue: holds finished results until the consumer pops them.
module plbf_outq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          res_valid,
  input  plbf_pkg::out_item_t           res,
  output logic [plbf_pkg::OQ_CNT_W-1:0] level,
  output logic                          empty,
  input  logic                          pop,
  output plbf_pkg::out_item_t           out_data
);
  import plbf_pkg::*;

  out_item_t           entry_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r;
  logic [OQ_PTR_W-1:0] rd_ptr_r;
  logic [OQ_CNT_W-1:0] count_r;
  logic                take;

  assign level    = count_r;
  assign empty    = (count_r == '0);
  assign take     = pop && !empty;
  assign out_data = entry_r[rd_ptr_r];

  // Store results; the back end reserves a slot before issuing
  always_ff @(posedge clk) begin
    if (res_valid) begin
      entry_r[wr_ptr_r] <= res;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr_r <= (wr_ptr_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (take) begin
        rd_ptr_r <= (rd_ptr_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({res_valid, take})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pcm_latency_bounded_fifo.sv
// Results pass the request queue, result stage and result queue before a pop.
// Throughput: one request per cycle while the result queue has room, set by
// the sample store (one read or one write per request) and the back end.
// Reset: synchronous, active low; clears pointers, fill, flags, totals and
// queues and loads a target of 1920. The sample store is not cleared.
// Top level of the PCM latency-bounded FIFO.
module pcm_latency_bounded_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  plbf_pkg::in_item_t          in_data,
  output logic                        empty,
  input  logic                        pop,
  output plbf_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [plbf_pkg::TGT_W-1:0]  cfg_wdata
);
  import plbf_pkg::*;

  logic                req_valid;
  req_t                req;
  logic                req_take;
  logic                res_valid;
  out_item_t           res;
  logic [OQ_CNT_W-1:0] oq_level;

  // Accept and classify requests
  plbf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take)
  );

  // Execute requests
  plbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take),
    .oq_level  (oq_level),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold results for the consumer
  plbf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .level     (oq_level),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

FILE: sim/tb.sv
// Testbench for the PCM latency-bounded FIFO: directed table, then random phases against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plbf_pkg::*;

  // Command code with no meaning to the block
  localparam logic [CMD_W-1:0]  CMD_NONE    = 2'd3;
  // Gating flags (feed, capture, protect) that open the path
  localparam logic [FLAG_N-1:0] GATE_OPEN   = 3'b110;
  localparam int                MAX_CYCLES  = 1_000_000;
  localparam int                HOLD_CYCLES = 300;
  localparam int                N_DIR       = 25;

  logic             clk;
  logic             rst_n;
  logic             push;
  logic             full;
  logic             empty;
  logic             pop;
  logic             cfg_we;
  logic [TGT_W-1:0] cfg_wdata;
  in_item_t         in_data;
  out_item_t        out_data;

  pcm_latency_bounded_fifo dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Directed request with an optional typed-in result
  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [SAMPLE_W-1:0] smp;
    logic [FLAG_N-1:0]   flg;
    bit                  typed;
    out_item_t           want;
  } dir_row_t;

  dir_row_t dir_tab [N_DIR] = '{
    '{CMD_PUSH,  16'hFFFF, 3'b000, 1'b1, '{16'h0, 1'b0, 13'd0, 64'd0, 64'd0, 64'd0}},
    '{CMD_POP,   16'h0000, 3'b000, 1'b1, '{16'h0, 1'b0, 13'd0, 64'd0, 64'd2, 64'd0}},
    '{CMD_NONE,  16'hA5A5, 3'b111, 1'b1, '{16'h0, 1'b0, 13'd0, 64'd0, 64'd2, 64'd0}},
    '{CMD_FLAGS, 16'h0000, 3'b100, 1'b1, '{16'h0, 1'b0, 13'd0, 64'd0, 64'd2, 64'd1}},
    '{CMD_FLAGS, 16'h0000, 3'b110, 1'b1, '{16'h0, 1'b0, 13'd0, 64'd0, 64'd2, 64'd2}},
    '{CMD_PUSH,  16'h0000, 3'b000, 1'b0, '0},
    '{CMD_PUSH,  16'hFFFF, 3'b111, 1'b0, '0},
    '{CMD_PUSH,  16'h8001, 3'b010, 1'b0, '0},
    '{CMD_POP,   16'hFFFF, 3'b000, 1'b0, '0},
    '{CMD_POP,   16'h0000, 3'b000, 1'b0, '0},
    '{CMD_POP,   16'h0000, 3'b000, 1'b0, '0},
    '{CMD_POP,   16'h0000, 3'b000, 1'b1, '{16'h0, 1'b0, 13'd0, 64'd0, 64'd4, 64'd2}},
    '{CMD_FLAGS, 16'h0000, 3'b111, 1'b1, '{16'h0, 1'b0, 13'd0, 64'd0, 64'd4, 64'd3}},
    '{CMD_PUSH,  16'h7FFF, 3'b000, 1'b1, '{16'h0, 1'b0, 13'd0, 64'd0, 64'd4, 64'd3}},
    '{CMD_POP,   16'h0000, 3'b000, 1'b1, '{16'h0, 1'b0, 13'd0, 64'd0, 64'd6, 64'd3}},
    '{CMD_FLAGS, 16'h0000, 3'b000, 1'b1, '{16'h0, 1'b0, 13'd0, 64'd0, 64'd6, 64'd6}},
    '{CMD_FLAGS, 16'hFFFF, 3'b000, 1'b1, '{16'h0, 1'b0, 13'd0, 64'd0, 64'd6, 64'd6}},
    '{CMD_FLAGS, 16'h0000, 3'b110, 1'b1, '{16'h0, 1'b0, 13'd0, 64'd0, 64'd6, 64'd8}},
    '{CMD_PUSH,  16'h1234, 3'b001, 1'b0, '0},
    '{CMD_PUSH,  16'h5678, 3'b000, 1'b0, '0},
    '{CMD_FLAGS, 16'h0000, 3'b110, 1'b0, '0},
    '{CMD_NONE,  16'hFFFF, 3'b001, 1'b0, '0},
    '{CMD_FLAGS, 16'h0000, 3'b010, 1'b0, '0},
    '{CMD_FLAGS, 16'h0000, 3'b110, 1'b0, '0},
    '{CMD_POP,   16'h0000, 3'b000, 1'b0, '0}
  };

  // Predictor state
  logic [SAMPLE_W-1:0] pcm_copy [FIFO_DEPTH];
  int unsigned         head_idx;
  int unsigned         fill_cnt;
  int unsigned         target_fill;
  logic [FLAG_N-1:0]   gate;
  logic [TOT_W-1:0]    ovf_bytes;
  logic [TOT_W-1:0]    unf_bytes;
  logic [TOT_W-1:0]    clears;

  // Results still owed by the block, oldest first
  out_item_t   result_q [$];

  int unsigned mismatches  = 0;
  int unsigned checked     = 0;
  int unsigned accepted    = 0;
  int unsigned full_stalls = 0;
  int unsigned cycles      = 0;
  bit          calm        = 1'b0;
  bit          hold_req    = 1'b0;
  int          rx_stall    = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Advance the predictor by one request and return the result it causes
  function automatic out_item_t fifo_step(input in_item_t it);
    out_item_t         r;
    int unsigned       lim;
    int unsigned       excess;
    int unsigned       drop;
    logic [FLAG_N-1:0] new_gate;
    r = '0;
    new_gate = {it.feed_on, it.capture_on, it.protect_on};
    case (it.cmd)
      CMD_PUSH: begin
        if (gate == GATE_OPEN) begin
          lim = (target_fill > FIFO_DEPTH) ? FIFO_DEPTH : target_fill;
          // drop oldest samples until the new one fits under the target
          if (fill_cnt + 1 > lim) begin
            excess = fill_cnt + 1 - lim;
            drop = (excess < fill_cnt) ? excess : fill_cnt;
            head_idx = (head_idx + drop) % FIFO_DEPTH;
            fill_cnt -= drop;
            ovf_bytes += TOT_W'(2 * drop);
            if (excess != drop) ovf_bytes += TOT_W'(2);
          end
          if (fill_cnt < lim) begin
            pcm_copy[(head_idx + fill_cnt) % FIFO_DEPTH] = it.sample_in;
            fill_cnt++;
          end
        end
      end
      CMD_POP: begin
        if (gate == GATE_OPEN && fill_cnt != 0) begin
          r.sample_out  = pcm_copy[head_idx];
          r.sample_real = 1'b1;
          head_idx = (head_idx + 1) % FIFO_DEPTH;
          fill_cnt--;
        end else begin
          unf_bytes += TOT_W'(2);
        end
      end
      CMD_FLAGS: begin
        // each changed flag empties the FIFO; stored data stays
        for (int i = FLAG_N - 1; i >= 0; i--) begin
          if (gate[i] != new_gate[i]) begin
            gate[i]  = new_gate[i];
            head_idx = 0;
            fill_cnt = 0;
            clears++;
          end
        end
      end
      default: ;
    endcase
    r.fill_samples    = FILL_W'(fill_cnt);
    r.overflow_bytes  = ovf_bytes;
    r.underflow_bytes = unf_bytes;
    r.clear_count     = clears;
    return r;
  endfunction

  function automatic void cmp_field(input string field, input logic [TOT_W-1:0] want,
                                    input logic [TOT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t exp_r;
    if (result_q.size() == 0) begin
      $display("%0t: unexpected result, expected none got %h", $time, got);
      mismatches++;
    end else begin
      exp_r = result_q.pop_front();
      cmp_field("sample_out", exp_r.sample_out, got.sample_out);
      cmp_field("sample_real", exp_r.sample_real, got.sample_real);
      cmp_field("fill_samples", exp_r.fill_samples, got.fill_samples);
      cmp_field("overflow_bytes", exp_r.overflow_bytes, got.overflow_bytes);
      cmp_field("underflow_bytes", exp_r.underflow_bytes, got.underflow_bytes);
      cmp_field("clear_count", exp_r.clear_count, got.clear_count);
      checked++;
    end
  endtask

  // Offer one request, hold it until accepted, then log its expected result
  task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t want = '0);
    int        gap;
    out_item_t predicted;
    gap = (!calm && $urandom_range(0, 9) == 0) ? int'($urandom_range(1, 19)) : 0;
    if (gap != 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    predicted = fifo_step(it);
    result_q.push_back(typed ? want : predicted);
    accepted++;
  endtask

  // Stop offering and wait for every owed result
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_target(input int unsigned v);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= TGT_W'(v);
    @(posedge clk);
    target_fill = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly pushes and pops on an open path, with some flag changes and noise
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned k;
    it.sample_in = SAMPLE_W'($urandom);
    {it.feed_on, it.capture_on, it.protect_on} = FLAG_N'($urandom);
    k = $urandom_range(0, 99);
    if (k < 46) begin
      it.cmd = CMD_PUSH;
    end else if (k < 90) begin
      it.cmd = CMD_POP;
    end else if (k < 97) begin
      it.cmd = CMD_FLAGS;
      // reopen the path more often than not
      if ($urandom_range(0, 2) != 0) {it.feed_on, it.capture_on, it.protect_on} = GATE_OPEN;
    end else begin
      it.cmd = CMD_NONE;
    end
    return it;
  endfunction

  // Set a target, open the path, push a lead-in burst, then random requests
  task automatic run_phase(input int unsigned tgt, input int lead, input int nrand,
                           input bit hold = 1'b0);
    in_item_t it;
    int       n;
    set_target(tgt);
    // start the long hold-off only once the phase is ready to send
    if (hold) hold_req = 1'b1;
    it = random_item();
    it.cmd = CMD_FLAGS;
    {it.feed_on, it.capture_on, it.protect_on} = GATE_OPEN;
    send_item(it);
    for (n = 0; n < lead; n++) begin
      it = random_item();
      it.cmd = CMD_PUSH;
      send_item(it);
    end
    for (n = 0; n < nrand; n++) send_item(random_item());
  endtask

  // Result side: random pop stalls, one long hold-off on request
  initial begin
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_stall = HOLD_CYCLES;
      end else if (rx_stall == 0 && !calm && $urandom_range(0, 9) == 0) begin
        rx_stall = $urandom_range(1, 19);
      end
      if (rx_stall > 0) begin
        pop <= 1'b0;
        rx_stall--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) check_result(out_data);
    end
  end

  // Stimulus
  initial begin
    in_item_t it;
    int       r;
    rst_n     <= 1'b0;
    push      <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    for (int a = 0; a < FIFO_DEPTH; a++) pcm_copy[a] = '0;
    head_idx    = 0;
    fill_cnt    = 0;
    target_fill = TGT_RESET;
    gate        = '0;
    ovf_bytes   = '0;
    unf_bytes   = '0;
    clears      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // walk the directed table at the reset target
    for (r = 0; r < N_DIR; r++) begin
      it.cmd       = dir_tab[r].cmd;
      it.sample_in = dir_tab[r].smp;
      {it.feed_on, it.capture_on, it.protect_on} = dir_tab[r].flg;
      send_item(it, dir_tab[r].typed, dir_tab[r].want);
    end

    // zero target: every open push overflows
    run_phase(0, 4, 40);
    run_phase(24, 30, 150);
    // lowered below the fill left by the previous phase
    run_phase(5, 3, 150);
    // push a long burst while the result side holds off
    run_phase(FIFO_DEPTH, 100, 0, 1'b1);
    // target above depth behaves as the depth
    run_phase(8191, 10, 0);
    // drop the whole backlog on the first push
    run_phase(1, 2, 150);
    run_phase(13, 0, 120);
    run_phase(8191, 0, 150);
    // no idling on either side from here on
    calm = 1'b1;
    run_phase(40, 0, 150);
    settle();
    repeat (8) @(posedge clk);

    $display("summary: %0d requests, %0d results checked, %0d cycles held off by full",
             accepted, checked, full_stalls);
    $display("summary: targets 0 to 8191, final overflow %0d underflow %0d clears %0d",
             ovf_bytes, unf_bytes, clears);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: pcm_latency_bounded_fifo.f
hw/rtl/plbf_pkg.sv
hw/rtl/plbf_front.sv
hw/rtl/plbf_back.sv
hw/rtl/plbf_outq.sv
hw/rtl/pcm_latency_bounded_fifo.sv
sim/tb.sv
